// ===== sv/itlc_pkg.sv =====
// Shared types for the track line counter.
// Used by the track cell and the top level; no dependencies.
package itlc_pkg;

   // Per-cell control: shift takes the neighbor's word, load takes the broadcast word.
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

   localparam int FLAG_BITS  = 4;
   localparam int CONF_BITS  = 8;
   localparam int IDENT_BITS = 16;
   localparam int COUNT_BITS = 16;

endpackage

// ===== sv/itlc_cell.sv =====
// One track cell of the track chain: holds one packed track entry.
// Depends on itlc_pkg for the cell control struct.
module itlc_cell #(
   parameter int DATA_W = 68
) (
   input  logic                      clock,
   input  itlc_pkg::cell_ctl_type    ctl,
   input  logic [DATA_W-1:0]         next_data,
   input  logic [DATA_W-1:0]         bcast_data,
   output logic [DATA_W-1:0]         data
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = bcast_data;
      end else if (ctl.shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== sv/itlc_side.sv =====
// Line side test unit: two products in one stage, sign compare in the next.
// No package dependencies.
module itlc_side #(
   parameter int COORD_BITS = 10
) (
   input  logic                      clock,
   input  logic [4*COORD_BITS-1:0]   line,
   input  logic [COORD_BITS:0]       px,
   input  logic [COORD_BITS:0]       py,
   output logic                      side
);

   localparam int DW = COORD_BITS + 2;
   localparam int PW = 2 * DW;

   logic [COORD_BITS-1:0] ax, ay, bx, by;
   logic signed [DW-1:0]  d_px, d_py, d_bx, d_by;
   logic signed [PW-1:0]  prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic                  side_ff, side_in;

   always_comb begin
      ax = line[3*COORD_BITS +: COORD_BITS];
      ay = line[2*COORD_BITS +: COORD_BITS];
      bx = line[COORD_BITS +: COORD_BITS];
      by = line[0 +: COORD_BITS];
      d_px = signed'({1'b0, px}) - signed'({2'b00, ax});
      d_py = signed'({1'b0, py}) - signed'({2'b00, ay});
      d_by = signed'({2'b00, by}) - signed'({2'b00, ay});
      d_bx = signed'({2'b00, bx}) - signed'({2'b00, ax});
      prod_a_in = d_px * d_by;
      prod_b_in = d_py * d_bx;
      // positive side when the cross product is negative
      side_in = prod_a_ff < prod_b_ff;
   end

   always_ff @(posedge clock) begin
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      side_ff   <= side_in;
   end

   assign side = side_ff;

endmodule

// ===== sv/iou_track_line_counter.sv =====
// Track table with IoU association and line-crossing counter; top level, uses itlc_pkg,
// itlc_cell and itlc_side. Detection: a single result after a pass over the live tracks.
// Tick: crossing events as the tracks are visited, then the summary.
// One item at a time, set by the walk of the chain through the shared IoU datapath and
// the line side unit; results cannot be stalled. Synchronous reset empties the table,
// clears counts and ids and loads register defaults; table contents need no clearing.
module iou_track_line_counter #(
   parameter int MAX_TRACKS = 16,
   parameter int COORD_BITS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_type,
   input  logic [COORD_BITS-1:0]     req_box_x,
   input  logic [COORD_BITS-1:0]     req_box_y,
   input  logic [COORD_BITS-1:0]     req_box_w,
   input  logic [COORD_BITS-1:0]     req_box_h,
   input  logic [7:0]                req_det_conf,
   input  logic [15:0]               req_frame_number,
   input  logic                      csr_write,
   input  logic [2:0]                csr_index,
   input  logic [4*COORD_BITS-1:0]   csr_data,
   output logic                      rsp_valid,
   output logic [3:0]                rsp_event_kind,
   output logic [15:0]               rsp_track_number,
   output logic [3:0]                rsp_slot_number,
   output logic [15:0]               rsp_in_total,
   output logic [15:0]               rsp_out_total,
   output logic [15:0]               rsp_frame_tag,
   output logic [4:0]                rsp_live_tracks,
   output logic                      rsp_last
);

   localparam int CW    = COORD_BITS;
   localparam int LW    = 4 * CW;
   localparam int CNTW  = $clog2(MAX_TRACKS + 1);
   localparam int FLW   = itlc_pkg::FLAG_BITS;
   localparam int CFW   = itlc_pkg::CONF_BITS;
   localparam int IDW   = itlc_pkg::IDENT_BITS;
   localparam int CTW   = itlc_pkg::COUNT_BITS;
   localparam int O_ID  = FLW;
   localparam int O_CF  = FLW + IDW;
   localparam int O_BOX = FLW + IDW + CFW;
   localparam int ENTW  = O_BOX + LW;
   localparam int AW    = 2 * CW;
   localparam int UW    = AW + 1;

   localparam logic [3:0] EV_MERGED   = 4'd0;
   localparam logic [3:0] EV_KEPT     = 4'd1;
   localparam logic [3:0] EV_NEW      = 4'd2;
   localparam logic [3:0] EV_DROPPED  = 4'd3;
   localparam logic [3:0] EV_IN       = 4'd4;
   localparam logic [3:0] EV_OUT      = 4'd5;
   localparam logic [3:0] EV_BACK_IN  = 4'd6;
   localparam logic [3:0] EV_BACK_OUT = 4'd7;
   localparam logic [3:0] EV_SUMMARY  = 4'd8;

   localparam logic [2:0] REG_LINE_INSIDE  = 3'd0;
   localparam logic [2:0] REG_LINE_OUTSIDE = 3'd1;
   localparam logic [2:0] REG_BOUND_ONE    = 3'd2;
   localparam logic [2:0] REG_BOUND_TWO    = 3'd3;
   localparam logic [2:0] REG_IOU_THR      = 3'd4;
   localparam logic [2:0] REG_CONF_DECAY   = 3'd5;
   localparam logic [2:0] REG_KEEP_THR     = 3'd6;

   localparam logic [1:0] LN_BOUND_ONE = 2'd0;
   localparam logic [1:0] LN_BOUND_TWO = 2'd1;
   localparam logic [1:0] LN_INSIDE    = 2'd2;
   localparam logic [1:0] LN_OUTSIDE   = 2'd3;
   localparam logic [2:0] LC_FIRST_OUT = 3'd2;
   localparam logic [2:0] LC_LAST      = 3'd5;

   localparam int F_BI = 0;
   localparam int F_BO = 1;
   localparam int F_CI = 2;
   localparam int F_CO = 3;

   localparam logic REQ_DETECT = 1'b0;

   typedef enum logic [3:0] {
      S_IDLE, S_D_AREA, S_D_A, S_D_B, S_D_C, S_D_D, S_D_E, S_D_FIN,
      S_T_A, S_T_LN, S_T_IN, S_T_OUT, S_T_SUM
   } state_type;

   state_type state_ff, state_in;

   logic [LW-1:0]   line_in_ff, line_in_in, line_out_ff, line_out_in;
   logic [LW-1:0]   bound_one_ff, bound_one_in, bound_two_ff, bound_two_in;
   logic [7:0]      iou_thr_ff, iou_thr_in, decay_ff, decay_in, keep_thr_ff, keep_thr_in;

   logic [CNTW-1:0] total_ff, total_in, k_ff, k_in, len_ff, len_in, before_ff, before_in;
   logic [IDW-1:0]  next_id_ff, next_id_in;
   logic [CTW-1:0]  in_cnt_ff, in_cnt_in, out_cnt_ff, out_cnt_in;

   logic [CW-1:0]   det_x_ff, det_x_in, det_y_ff, det_y_in;
   logic [CW-1:0]   det_w_ff, det_w_in, det_h_ff, det_h_in;
   logic [CFW-1:0]  det_conf_ff, det_conf_in;
   logic [15:0]     frame_ff, frame_in;

   logic [AW-1:0]   area_d_ff, area_d_in, area_t_ff, area_t_in, inter_ff, inter_in;
   logic [CW:0]     ov_x_ff, ov_x_in, ov_y_ff, ov_y_in;
   logic [UW-1:0]   uni_ff, uni_in;
   logic [UW+7:0]   thr_u_ff, thr_u_in;
   logic [AW+UW-1:0] cross_a_ff, cross_a_in, cross_b_ff, cross_b_in;
   logic            best_valid_ff, best_valid_in;
   logic [AW-1:0]   best_i_ff, best_i_in;
   logic [UW-1:0]   best_u_ff, best_u_in;
   logic [CNTW-1:0] best_slot_ff, best_slot_in;
   logic [CFW-1:0]  best_conf_ff, best_conf_in;
   logic [IDW-1:0]  best_id_ff, best_id_in;
   logic [FLW-1:0]  best_flags_ff, best_flags_in;

   logic [CW:0]     px_ff, px_in, py_ff, py_in;
   logic [2:0]      lc_ff, lc_in;
   logic [3:0]      side_ff, side_in;
   logic [FLW-1:0]  wflags_ff, wflags_in;

   logic            rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [3:0]      rsp_kind_ff, rsp_kind_in, rsp_slot_ff, rsp_slot_in;
   logic [15:0]     rsp_id_ff, rsp_id_in, rsp_in_ff, rsp_in_in, rsp_out_ff, rsp_out_in;
   logic [15:0]     rsp_frame_ff, rsp_frame_in;
   logic [4:0]      rsp_live_ff, rsp_live_in;

   // track chain
   itlc_pkg::cell_ctl_type cell_ctl [MAX_TRACKS];
   logic [ENTW-1:0] cell_q [MAX_TRACKS];
   logic [ENTW-1:0] bcast;
   logic            rot_en, push_en, wr_en;
   logic [CNTW-1:0] push_tail, wr_slot;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_TRACKS; gi++) begin : g_cell
         logic [ENTW-1:0] nxt;
         if (gi == MAX_TRACKS - 1) begin : g_end
            assign nxt = cell_q[gi];
         end else begin : g_mid
            assign nxt = cell_q[gi+1];
         end
         itlc_cell #(.DATA_W(ENTW)) u_cell (
            .clock      (clock),
            .ctl        (cell_ctl[gi]),
            .next_data  (nxt),
            .bcast_data (bcast),
            .data       (cell_q[gi])
         );
      end
   endgenerate

   // head of chain
   logic [ENTW-1:0] head;
   logic [CW-1:0]   h_x, h_y, h_w, h_h;
   logic [CFW-1:0]  h_conf;
   logic [IDW-1:0]  h_id;
   logic [FLW-1:0]  h_flags;

   assign head    = cell_q[0];
   assign h_x     = head[O_BOX + 3*CW +: CW];
   assign h_y     = head[O_BOX + 2*CW +: CW];
   assign h_w     = head[O_BOX + CW +: CW];
   assign h_h     = head[O_BOX +: CW];
   assign h_conf  = head[O_CF +: CFW];
   assign h_id    = head[O_ID +: IDW];
   assign h_flags = head[0 +: FLW];

   // line side unit
   logic [LW-1:0] line_sel;
   logic          side_out;

   always_comb begin
      case (lc_ff[1:0])
         LN_BOUND_ONE: line_sel = bound_one_ff;
         LN_BOUND_TWO: line_sel = bound_two_ff;
         LN_INSIDE:    line_sel = line_in_ff;
         LN_OUTSIDE:   line_sel = line_out_ff;
         default:      line_sel = line_in_ff;
      endcase
   end

   itlc_side #(.COORD_BITS(CW)) u_side (
      .clock (clock),
      .line  (line_sel),
      .px    (px_ff),
      .py    (py_ff),
      .side  (side_out)
   );

   assign busy = (state_ff != S_IDLE);

   // datapath temporaries
   logic [CW:0]      a_xe, a_ye, b_xe, b_ye, x1, y1, x2, y2;
   logic [2*CW+1:0]  inter_full;
   logic             match_ok, region, keep;
   logic [CFW-1:0]   dec_conf;
   logic [FLW-1:0]   fl;
   logic             emit, ev_last;
   logic [3:0]       ev_kind;
   logic [IDW-1:0]   ev_id;
   logic [CNTW-1:0]  ev_slot, ev_live;
   logic [15:0]      ev_frame;
   logic [CNTW+3:0]  slot_wide;
   logic [CNTW+4:0]  live_wide;
   logic [1:0]       side_idx;

   always_comb begin
      state_in      = state_ff;
      line_in_in    = line_in_ff;
      line_out_in   = line_out_ff;
      bound_one_in  = bound_one_ff;
      bound_two_in  = bound_two_ff;
      iou_thr_in    = iou_thr_ff;
      decay_in      = decay_ff;
      keep_thr_in   = keep_thr_ff;
      total_in      = total_ff;
      k_in          = k_ff;
      len_in        = len_ff;
      before_in     = before_ff;
      next_id_in    = next_id_ff;
      in_cnt_in     = in_cnt_ff;
      out_cnt_in    = out_cnt_ff;
      det_x_in      = det_x_ff;
      det_y_in      = det_y_ff;
      det_w_in      = det_w_ff;
      det_h_in      = det_h_ff;
      det_conf_in   = det_conf_ff;
      frame_in      = frame_ff;
      area_d_in     = area_d_ff;
      area_t_in     = area_t_ff;
      inter_in      = inter_ff;
      ov_x_in       = ov_x_ff;
      ov_y_in       = ov_y_ff;
      uni_in        = uni_ff;
      thr_u_in      = thr_u_ff;
      cross_a_in    = cross_a_ff;
      cross_b_in    = cross_b_ff;
      best_valid_in = best_valid_ff;
      best_i_in     = best_i_ff;
      best_u_in     = best_u_ff;
      best_slot_in  = best_slot_ff;
      best_conf_in  = best_conf_ff;
      best_id_in    = best_id_ff;
      best_flags_in = best_flags_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      lc_in         = lc_ff;
      side_in       = side_ff;
      wflags_in     = wflags_ff;

      rot_en    = 1'b0;
      push_en   = 1'b0;
      wr_en     = 1'b0;
      push_tail = len_ff - 1'b1;
      wr_slot   = best_slot_ff;
      bcast     = head;

      emit     = 1'b0;
      ev_kind  = EV_SUMMARY;
      ev_id    = '0;
      ev_slot  = k_ff;
      ev_live  = before_ff;
      ev_frame = frame_ff;
      ev_last  = 1'b0;

      a_xe = {1'b0, h_x} + {1'b0, h_w};
      a_ye = {1'b0, h_y} + {1'b0, h_h};
      b_xe = {1'b0, det_x_ff} + {1'b0, det_w_ff};
      b_ye = {1'b0, det_y_ff} + {1'b0, det_h_ff};
      x1 = (h_x > det_x_ff) ? {1'b0, h_x} : {1'b0, det_x_ff};
      y1 = (h_y > det_y_ff) ? {1'b0, h_y} : {1'b0, det_y_ff};
      x2 = (a_xe < b_xe) ? a_xe : b_xe;
      y2 = (a_ye < b_ye) ? a_ye : b_ye;
      inter_full = ov_x_ff * ov_y_ff;
      match_ok = (uni_ff != '0) && ({1'b0, inter_ff, 8'h00} > thr_u_ff)
                 && (!best_valid_ff || (cross_a_ff > cross_b_ff));
      region   = side_ff[0] & side_ff[1];
      dec_conf = (h_conf > decay_ff) ? (h_conf - decay_ff) : '0;
      keep     = dec_conf > keep_thr_ff;
      fl       = wflags_ff;
      side_idx = 2'(lc_ff - LC_FIRST_OUT);

      if (csr_write) begin
         case (csr_index)
            REG_LINE_INSIDE:  line_in_in   = csr_data;
            REG_LINE_OUTSIDE: line_out_in  = csr_data;
            REG_BOUND_ONE:    bound_one_in = csr_data;
            REG_BOUND_TWO:    bound_two_in = csr_data;
            REG_IOU_THR:      iou_thr_in   = csr_data[7:0];
            REG_CONF_DECAY:   decay_in     = csr_data[7:0];
            REG_KEEP_THR:     keep_thr_in  = csr_data[7:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               det_x_in    = req_box_x;
               det_y_in    = req_box_y;
               det_w_in    = req_box_w;
               det_h_in    = req_box_h;
               det_conf_in = req_det_conf;
               frame_in    = req_frame_number;
               k_in        = '0;
               before_in   = total_ff;
               len_in      = total_ff;
               if (req_type == REQ_DETECT) begin
                  best_valid_in = 1'b0;
                  best_i_in     = '0;
                  best_u_in     = UW'(1);
                  state_in      = S_D_AREA;
               end else if (total_ff == '0) begin
                  state_in = S_T_SUM;
               end else begin
                  state_in = S_T_A;
               end
            end
         end
         S_D_AREA: begin
            area_d_in = det_w_ff * det_h_ff;
            state_in  = (total_ff == '0) ? S_D_FIN : S_D_A;
         end
         S_D_A: begin
            ov_x_in   = ((x2 >= x1) && (y2 >= y1)) ? (x2 - x1) : '0;
            ov_y_in   = ((x2 >= x1) && (y2 >= y1)) ? (y2 - y1) : '0;
            area_t_in = h_w * h_h;
            state_in  = S_D_B;
         end
         S_D_B: begin
            inter_in = inter_full[AW-1:0];
            state_in = S_D_C;
         end
         S_D_C: begin
            uni_in   = {1'b0, area_t_ff} + {1'b0, area_d_ff} - {1'b0, inter_ff};
            state_in = S_D_D;
         end
         S_D_D: begin
            thr_u_in   = iou_thr_ff * uni_ff;
            cross_a_in = inter_ff * best_u_ff;
            cross_b_in = best_i_ff * uni_ff;
            state_in   = S_D_E;
         end
         S_D_E: begin
            if (match_ok) begin
               best_valid_in = 1'b1;
               best_i_in     = inter_ff;
               best_u_in     = uni_ff;
               best_slot_in  = k_ff;
               best_conf_in  = h_conf;
               best_id_in    = h_id;
               best_flags_in = h_flags;
            end
            // rotate the head to the tail, order restored after a full pass
            rot_en    = 1'b1;
            push_en   = 1'b1;
            push_tail = total_ff - 1'b1;
            k_in      = k_ff + 1'b1;
            state_in  = (k_ff == total_ff - 1'b1) ? S_D_FIN : S_D_A;
         end
         S_D_FIN: begin
            emit     = 1'b1;
            ev_last  = 1'b1;
            ev_frame = '0;
            if (best_valid_ff) begin
               ev_id   = best_id_ff;
               ev_slot = best_slot_ff;
               ev_live = total_ff;
               if (best_conf_ff > det_conf_ff) begin
                  ev_kind = EV_KEPT;
               end else begin
                  ev_kind = EV_MERGED;
                  wr_en   = 1'b1;
                  wr_slot = best_slot_ff;
                  bcast   = {det_x_ff, det_y_ff, det_w_ff, det_h_ff, det_conf_ff,
                             best_id_ff, best_flags_ff};
               end
            end else if (total_ff < CNTW'(MAX_TRACKS)) begin
               ev_kind    = EV_NEW;
               ev_id      = next_id_ff;
               ev_slot    = total_ff;
               ev_live    = total_ff + 1'b1;
               wr_en      = 1'b1;
               wr_slot    = total_ff;
               bcast      = {det_x_ff, det_y_ff, det_w_ff, det_h_ff, det_conf_ff,
                             next_id_ff, {FLW{1'b0}}};
               next_id_in = next_id_ff + 1'b1;
               total_in   = total_ff + 1'b1;
            end else begin
               ev_kind = EV_DROPPED;
               ev_slot = '0;
               ev_live = total_ff;
            end
            state_in = S_IDLE;
         end
         S_T_A: begin
            px_in    = {1'b0, h_x} + {2'b00, h_w[CW-1:1]};
            py_in    = {1'b0, h_y} + {3'b000, h_h[CW-1:2]};
            lc_in    = '0;
            state_in = S_T_LN;
         end
         S_T_LN: begin
            // lines issue on counts 0..3; sides return after the side registers
            if (lc_ff >= LC_FIRST_OUT) begin
               side_in[side_idx] = side_out;
            end
            lc_in = lc_ff + 1'b1;
            if (lc_ff == LC_LAST) begin
               state_in = S_T_IN;
            end
         end
         S_T_IN: begin
            fl = h_flags;
            if (region && side_ff[2]) begin
               fl[F_BI] = 1'b1;
               if (fl[F_BO] && !fl[F_CI] && !fl[F_CO]) begin
                  if (in_cnt_ff != '1) in_cnt_in = in_cnt_ff + 1'b1;
                  fl[F_CI] = 1'b1;
                  emit     = 1'b1;
                  ev_kind  = EV_IN;
               end else if (fl[F_BO] && fl[F_CO]) begin
                  if (out_cnt_ff != '0) out_cnt_in = out_cnt_ff - 1'b1;
                  fl[F_CO] = 1'b0;
                  fl[F_BO] = 1'b0;
                  emit     = 1'b1;
                  ev_kind  = EV_BACK_IN;
               end
            end
            ev_id     = h_id;
            wflags_in = fl;
            state_in  = S_T_OUT;
         end
         S_T_OUT: begin
            if (region && side_ff[3]) begin
               fl[F_BO] = 1'b1;
               if (fl[F_BI] && !fl[F_CO] && !fl[F_CI]) begin
                  if (out_cnt_ff != '1) out_cnt_in = out_cnt_ff + 1'b1;
                  fl[F_CO] = 1'b1;
                  emit     = 1'b1;
                  ev_kind  = EV_OUT;
               end else if (fl[F_BI] && fl[F_CI]) begin
                  if (in_cnt_ff != '0) in_cnt_in = in_cnt_ff - 1'b1;
                  fl[F_CI] = 1'b0;
                  fl[F_BI] = 1'b0;
                  emit     = 1'b1;
                  ev_kind  = EV_BACK_OUT;
               end
            end
            ev_id = h_id;
            // pop the head; push it back only if it survives, which compacts
            rot_en    = 1'b1;
            push_en   = keep;
            push_tail = len_ff - 1'b1;
            bcast     = {h_x, h_y, h_w, h_h, dec_conf, h_id, fl};
            len_in    = keep ? len_ff : len_ff - 1'b1;
            k_in      = k_ff + 1'b1;
            state_in  = (k_ff == before_ff - 1'b1) ? S_T_SUM : S_T_A;
         end
         S_T_SUM: begin
            total_in = len_ff;
            emit     = 1'b1;
            ev_kind  = EV_SUMMARY;
            ev_slot  = '0;
            ev_live  = len_ff;
            ev_last  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      for (int i = 0; i < MAX_TRACKS; i++) begin
         cell_ctl[i].shift = rot_en;
         cell_ctl[i].load  = (rot_en && push_en && (CNTW'(i) == push_tail))
                             || (wr_en && (CNTW'(i) == wr_slot));
      end

      slot_wide    = {4'b0000, ev_slot};
      live_wide    = {5'b00000, ev_live};
      rsp_valid_in = emit;
      rsp_kind_in  = emit ? ev_kind : rsp_kind_ff;
      rsp_id_in    = emit ? ev_id : rsp_id_ff;
      rsp_slot_in  = emit ? slot_wide[3:0] : rsp_slot_ff;
      rsp_in_in    = emit ? in_cnt_in : rsp_in_ff;
      rsp_out_in   = emit ? out_cnt_in : rsp_out_ff;
      rsp_frame_in = emit ? ev_frame : rsp_frame_ff;
      rsp_live_in  = emit ? live_wide[4:0] : rsp_live_ff;
      rsp_last_in  = emit ? ev_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         line_in_ff   <= '0;
         line_out_ff  <= '0;
         bound_one_ff <= '0;
         bound_two_ff <= '0;
         iou_thr_ff   <= 8'd102;
         decay_ff     <= 8'd13;
         keep_thr_ff  <= 8'd51;
         total_ff     <= '0;
         next_id_ff   <= '0;
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         line_in_ff   <= line_in_in;
         line_out_ff  <= line_out_in;
         bound_one_ff <= bound_one_in;
         bound_two_ff <= bound_two_in;
         iou_thr_ff   <= iou_thr_in;
         decay_ff     <= decay_in;
         keep_thr_ff  <= keep_thr_in;
         total_ff     <= total_in;
         next_id_ff   <= next_id_in;
         in_cnt_ff    <= in_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff          <= k_in;
      len_ff        <= len_in;
      before_ff     <= before_in;
      det_x_ff      <= det_x_in;
      det_y_ff      <= det_y_in;
      det_w_ff      <= det_w_in;
      det_h_ff      <= det_h_in;
      det_conf_ff   <= det_conf_in;
      frame_ff      <= frame_in;
      area_d_ff     <= area_d_in;
      area_t_ff     <= area_t_in;
      inter_ff      <= inter_in;
      ov_x_ff       <= ov_x_in;
      ov_y_ff       <= ov_y_in;
      uni_ff        <= uni_in;
      thr_u_ff      <= thr_u_in;
      cross_a_ff    <= cross_a_in;
      cross_b_ff    <= cross_b_in;
      best_valid_ff <= best_valid_in;
      best_i_ff     <= best_i_in;
      best_u_ff     <= best_u_in;
      best_slot_ff  <= best_slot_in;
      best_conf_ff  <= best_conf_in;
      best_id_ff    <= best_id_in;
      best_flags_ff <= best_flags_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      lc_ff         <= lc_in;
      side_ff       <= side_in;
      wflags_ff     <= wflags_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_in_ff     <= rsp_in_in;
      rsp_out_ff    <= rsp_out_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_live_ff   <= rsp_live_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_track_number = rsp_id_ff;
   assign rsp_slot_number  = rsp_slot_ff;
   assign rsp_in_total     = rsp_in_ff;
   assign rsp_out_total    = rsp_out_ff;
   assign rsp_frame_tag    = rsp_frame_ff;
   assign rsp_live_tracks  = rsp_live_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== verif/itlc_tb_pkg.sv =====
// Register indexes and result kinds shared by the track counter testbench.
// Used by the checker and the testbench top; no dependencies.
`timescale 1ns / 1ps
package itlc_tb_pkg;

   typedef enum logic [2:0] {
      REG_LINE_INSIDE    = 3'd0,
      REG_LINE_OUTSIDE   = 3'd1,
      REG_LINE_BOUND_ONE = 3'd2,
      REG_LINE_BOUND_TWO = 3'd3,
      REG_IOU_THRESHOLD  = 3'd4,
      REG_CONF_DECAY     = 3'd5,
      REG_KEEP_THRESHOLD = 3'd6,
      REG_UNUSED         = 3'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      EV_MERGED   = 4'd0,
      EV_KEPT     = 4'd1,
      EV_NEW      = 4'd2,
      EV_DROPPED  = 4'd3,
      EV_IN       = 4'd4,
      EV_OUT      = 4'd5,
      EV_BACK_IN  = 4'd6,
      EV_BACK_OUT = 4'd7,
      EV_SUMMARY  = 4'd8
   } event_type;

   localparam logic REQ_DETECT = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

endpackage

// ===== verif/itlc_checker.sv =====
// Track counter checker: predicts tracker events from accepted words and config
// writes, and compares each result word. Depends on itlc_tb_pkg.
`timescale 1ns / 1ps
module itlc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_type,
   input  logic [9:0]  req_box_x,
   input  logic [9:0]  req_box_y,
   input  logic [9:0]  req_box_w,
   input  logic [9:0]  req_box_h,
   input  logic [7:0]  req_det_conf,
   input  logic [15:0] req_frame_number,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [39:0] csr_data,
   input  logic        rsp_valid,
   input  logic [3:0]  rsp_event_kind,
   input  logic [15:0] rsp_track_number,
   input  logic [3:0]  rsp_slot_number,
   input  logic [15:0] rsp_in_total,
   input  logic [15:0] rsp_out_total,
   input  logic [15:0] rsp_frame_tag,
   input  logic [4:0]  rsp_live_tracks,
   input  logic        rsp_last,
   output int          fail_count,
   output int          outstanding
);

   localparam int SLOTS = 16;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] ident;
      logic [3:0]  slot;
      logic [15:0] in_total;
      logic [15:0] out_total;
      logic [15:0] frame;
      logic [4:0]  live;
      logic        last;
   } event_word_type;

   event_word_type pending_events[$];

   logic [39:0] ln_inside, ln_outside, ln_bound_one, ln_bound_two;
   logic [7:0]  iou_thr, decay, keep_thr;
   logic [9:0]  tbox[SLOTS][4];
   logic [7:0]  tconf[SLOTS];
   logic [15:0] tident[SLOTS];
   logic [3:0]  tflags[SLOTS];
   int          ntracks;
   logic [15:0] ident_next, in_cnt, out_cnt;

   assign outstanding = pending_events.size();

   function automatic bit positive_side(logic [39:0] ln, longint px, longint py);
      longint ax, ay, bx, by;
      ax = ln[39:30];
      ay = ln[29:20];
      bx = ln[19:10];
      by = ln[9:0];
      return ((px - ax) * (by - ay) - (py - ay) * (bx - ax)) < 0;
   endfunction

   function automatic void push_event(logic [3:0] kind, logic [15:0] ident, int slot,
                                      logic [15:0] frame, int live, logic last);
      event_word_type ev;
      ev.kind = kind;
      ev.ident = ident;
      ev.slot = slot[3:0];
      ev.in_total = in_cnt;
      ev.out_total = out_cnt;
      ev.frame = frame;
      ev.live = live[4:0];
      ev.last = last;
      pending_events.insert(pending_events.size(), ev);
   endfunction

   function automatic void associate_detection();
      longint d[4], inter, uni, best_i, best_u, x1, y1, x2, y2, t0, t1;
      int match, s;
      d[0] = req_box_x;
      d[1] = req_box_y;
      d[2] = req_box_w;
      d[3] = req_box_h;
      best_i = 0;
      best_u = 1;
      match = -1;
      for (int k = 0; k < ntracks; k++) begin
         x1 = (tbox[k][0] > d[0]) ? tbox[k][0] : d[0];
         y1 = (tbox[k][1] > d[1]) ? tbox[k][1] : d[1];
         t0 = tbox[k][0] + tbox[k][2];
         t1 = d[0] + d[2];
         x2 = (t0 < t1) ? t0 : t1;
         t0 = tbox[k][1] + tbox[k][3];
         t1 = d[1] + d[3];
         y2 = (t0 < t1) ? t0 : t1;
         inter = (x2 >= x1 && y2 >= y1) ? (x2 - x1) * (y2 - y1) : 0;
         uni = longint'(tbox[k][2]) * tbox[k][3] + d[2] * d[3] - inter;
         if (uni != 0 && inter * 256 > longint'(iou_thr) * uni &&
             (match < 0 || inter * best_u > best_i * uni)) begin
            best_i = inter;
            best_u = uni;
            match = k;
         end
      end
      if (match >= 0) begin
         if (tconf[match] > req_det_conf) begin
            push_event(itlc_tb_pkg::EV_KEPT, tident[match], match, 16'd0, ntracks, 1'b1);
         end else begin
            for (int j = 0; j < 4; j++) tbox[match][j] = 10'(d[j]);
            tconf[match] = req_det_conf;
            push_event(itlc_tb_pkg::EV_MERGED, tident[match], match, 16'd0, ntracks, 1'b1);
         end
      end else if (ntracks < SLOTS) begin
         s = ntracks;
         for (int j = 0; j < 4; j++) tbox[s][j] = 10'(d[j]);
         tconf[s] = req_det_conf;
         tident[s] = ident_next;
         tflags[s] = 4'd0;
         ident_next++;
         ntracks++;
         push_event(itlc_tb_pkg::EV_NEW, tident[s], s, 16'd0, ntracks, 1'b1);
      end else begin
         push_event(itlc_tb_pkg::EV_DROPPED, 16'd0, 0, 16'd0, ntracks, 1'b1);
      end
   endfunction

   function automatic void advance_frame();
      int live_before, kept;
      longint px, py;
      bit bi, bo, ci, co;
      live_before = ntracks;
      kept = 0;
      for (int k = 0; k < live_before; k++) begin
         px = tbox[k][0] + tbox[k][2] / 2;
         py = tbox[k][1] + tbox[k][3] / 4;
         if (positive_side(ln_bound_one, px, py) && positive_side(ln_bound_two, px, py))
         begin
            {co, ci, bo, bi} = tflags[k];
            if (positive_side(ln_inside, px, py)) begin
               bi = 1;
               if (bo && !ci && !co) begin
                  if (in_cnt != 16'hFFFF) in_cnt++;
                  ci = 1;
                  push_event(itlc_tb_pkg::EV_IN, tident[k], k, req_frame_number,
                             live_before, 1'b0);
               end
               if (bo && co) begin
                  if (out_cnt != 0) out_cnt--;
                  co = 0;
                  bo = 0;
                  push_event(itlc_tb_pkg::EV_BACK_IN, tident[k], k, req_frame_number,
                             live_before, 1'b0);
               end
            end
            if (positive_side(ln_outside, px, py)) begin
               bo = 1;
               if (bi && !co && !ci) begin
                  if (out_cnt != 16'hFFFF) out_cnt++;
                  co = 1;
                  push_event(itlc_tb_pkg::EV_OUT, tident[k], k, req_frame_number,
                             live_before, 1'b0);
               end
               if (bi && ci) begin
                  if (in_cnt != 0) in_cnt--;
                  ci = 0;
                  bi = 0;
                  push_event(itlc_tb_pkg::EV_BACK_OUT, tident[k], k, req_frame_number,
                             live_before, 1'b0);
               end
            end
            tflags[k] = {co, ci, bo, bi};
         end
         tconf[k] = (tconf[k] > decay) ? tconf[k] - decay : 8'd0;
         if (tconf[k] > keep_thr) begin
            tbox[kept] = tbox[k];
            tconf[kept] = tconf[k];
            tident[kept] = tident[k];
            tflags[kept] = tflags[k];
            kept++;
         end
      end
      ntracks = kept;
      push_event(itlc_tb_pkg::EV_SUMMARY, 16'd0, 0, req_frame_number, ntracks, 1'b1);
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t: result word %s got %0d expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      event_word_type ev;
      if (reset) begin
         pending_events.delete();
         ln_inside = '0;
         ln_outside = '0;
         ln_bound_one = '0;
         ln_bound_two = '0;
         iou_thr = 8'd102;
         decay = 8'd13;
         keep_thr = 8'd51;
         ntracks = 0;
         ident_next = '0;
         in_cnt = '0;
         out_cnt = '0;
      end else begin
         if (rsp_valid) begin
            if (pending_events.size() == 0) begin
               $display("%0t: unexpected result word, kind %0d", $time, rsp_event_kind);
               fail_count++;
            end else begin
               ev = pending_events.pop_front();
               if (rsp_event_kind !== ev.kind)
                  report_mismatch("event_kind", rsp_event_kind, ev.kind);
               if (rsp_track_number !== ev.ident)
                  report_mismatch("track_number", rsp_track_number, ev.ident);
               if (rsp_slot_number !== ev.slot)
                  report_mismatch("slot_number", rsp_slot_number, ev.slot);
               if (rsp_in_total !== ev.in_total)
                  report_mismatch("in_total", rsp_in_total, ev.in_total);
               if (rsp_out_total !== ev.out_total)
                  report_mismatch("out_total", rsp_out_total, ev.out_total);
               if (rsp_frame_tag !== ev.frame)
                  report_mismatch("frame_tag", rsp_frame_tag, ev.frame);
               if (rsp_live_tracks !== ev.live)
                  report_mismatch("live_tracks", rsp_live_tracks, ev.live);
               if (rsp_last !== ev.last)
                  report_mismatch("last", rsp_last, ev.last);
            end
         end
         if (csr_write) begin
            case (itlc_tb_pkg::reg_index_type'(csr_index))
               itlc_tb_pkg::REG_LINE_INSIDE:    ln_inside = csr_data;
               itlc_tb_pkg::REG_LINE_OUTSIDE:   ln_outside = csr_data;
               itlc_tb_pkg::REG_LINE_BOUND_ONE: ln_bound_one = csr_data;
               itlc_tb_pkg::REG_LINE_BOUND_TWO: ln_bound_two = csr_data;
               itlc_tb_pkg::REG_IOU_THRESHOLD:  iou_thr = csr_data[7:0];
               itlc_tb_pkg::REG_CONF_DECAY:     decay = csr_data[7:0];
               itlc_tb_pkg::REG_KEEP_THRESHOLD: keep_thr = csr_data[7:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_type == itlc_tb_pkg::REQ_TICK) advance_frame();
            else associate_detection();
         end
      end
   end

endmodule

// ===== verif/tb_iou_track_line_counter.sv =====
// Testbench top for iou_track_line_counter: drives detections, frame ticks and
// config writes through idling phases. Depends on itlc_tb_pkg and itlc_checker.
`timescale 1ns / 1ps
module tb_iou_track_line_counter;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int ANCHORS = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_type = 1'b0;
   logic [9:0]  req_box_x = '0, req_box_y = '0, req_box_w = '0, req_box_h = '0;
   logic [7:0]  req_det_conf = '0;
   logic [15:0] req_frame_number = '0;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [39:0] csr_data = '0;
   logic        rsp_valid;
   logic [3:0]  rsp_event_kind;
   logic [15:0] rsp_track_number;
   logic [3:0]  rsp_slot_number;
   logic [15:0] rsp_in_total, rsp_out_total, rsp_frame_tag;
   logic [4:0]  rsp_live_tracks;
   logic        rsp_last;
   int          fail_count, outstanding;
   int          quiet_cycles = 0;
   int          idle_pct = 0;
   logic [15:0] frame_seq = '0;
   int          anchor_x[ANCHORS], anchor_y[ANCHORS], anchor_dir[ANCHORS];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   iou_track_line_counter i_dut (.*);

   itlc_checker i_checker (.*);

   // Watchdog: trip when no word moves for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: nothing accepted for %0d cycles", quiet_cycles);
         $display("** iou_track_line_counter: FAILED **");
         $finish;
      end
   end

   task automatic send_word(input logic kind, input logic [9:0] x, y, w, h,
                            input logic [7:0] conf, input logic [15:0] frame);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock) start = 1'b0;
      end
      @(negedge clock);
      start = 1'b1;
      req_type = kind;
      req_box_x = x;
      req_box_y = y;
      req_box_w = w;
      req_box_h = h;
      req_det_conf = conf;
      req_frame_number = frame;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_tick();
      frame_seq = frame_seq + 16'($urandom_range(1, 3));
      send_word(itlc_tb_pkg::REQ_TICK, 10'($urandom), 10'($urandom), 10'($urandom),
                10'($urandom), 8'($urandom),
                ($urandom_range(9) == 0) ? 16'($urandom) : frame_seq);
   endtask

   task automatic wait_drained();
      @(negedge clock) start = 1'b0;
      while (outstanding != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input itlc_tb_pkg::reg_index_type idx, input logic [39:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock) csr_write = 1'b0;
   endtask

   function automatic logic [39:0] pack_line(int ax, int ay, int bx, int by);
      return {10'(ax), 10'(ay), 10'(bx), 10'(by)};
   endfunction

   // Region covers the frame; inside line at x=500, outside line at x=600.
   task automatic write_crossing_lines();
      write_reg(itlc_tb_pkg::REG_LINE_BOUND_ONE, pack_line(0, 0, 1023, 0));
      write_reg(itlc_tb_pkg::REG_LINE_BOUND_TWO, pack_line(1023, 1023, 0, 1023));
      write_reg(itlc_tb_pkg::REG_LINE_INSIDE, pack_line(500, 0, 500, 1023));
      write_reg(itlc_tb_pkg::REG_LINE_OUTSIDE, pack_line(600, 1023, 600, 0));
   endtask

   task automatic random_phase(input int count);
      int a, r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 18) begin
            send_tick();
         end else if (r < 30) begin
            send_word(itlc_tb_pkg::REQ_DETECT, 10'($urandom), 10'($urandom),
                      10'($urandom), 10'($urandom), 8'($urandom), 16'($urandom));
         end else begin
            // Move an anchored object in small steps so it keeps matching its track.
            a = $urandom_range(ANCHORS - 1);
            if ($urandom_range(9) == 0) anchor_dir[a] = -anchor_dir[a];
            anchor_x[a] = anchor_x[a] + anchor_dir[a] * $urandom_range(0, 12);
            if (anchor_x[a] < 350 || anchor_x[a] > 700) anchor_dir[a] = -anchor_dir[a];
            send_word(itlc_tb_pkg::REQ_DETECT, 10'(anchor_x[a] + $urandom_range(0, 3)),
                      10'(anchor_y[a] + $urandom_range(0, 3)),
                      10'(40 + $urandom_range(0, 3)), 10'(40 + $urandom_range(0, 3)),
                      8'($urandom_range(60, 255)), 16'($urandom));
         end
      end
   endtask

   initial begin
      for (int a = 0; a < ANCHORS; a++) begin
         anchor_x[a] = $urandom_range(380, 680);
         anchor_y[a] = 20 + a * 48;
         anchor_dir[a] = $urandom_range(1) ? 1 : -1;
      end
      repeat (2) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // Defaults, zero lines: empty tick, extremes, empty union and kept.
      send_tick();
      send_word(itlc_tb_pkg::REQ_DETECT, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'd255,
                16'hFFFF);
      send_word(itlc_tb_pkg::REQ_DETECT, 10'd0, 10'd0, 10'd0, 10'd0, 8'd0, 16'd0);
      send_word(itlc_tb_pkg::REQ_DETECT, 10'd0, 10'd0, 10'd0, 10'd0, 8'd9, 16'd0);
      send_word(itlc_tb_pkg::REQ_DETECT, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'd100,
                16'd0);
      send_word(itlc_tb_pkg::REQ_DETECT, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'd200,
                16'd0);
      send_tick();
      wait_drained();
      write_crossing_lines();
      write_reg(itlc_tb_pkg::REG_UNUSED, '1);
      // Fill the table past capacity with separate boxes, then tick.
      for (int k = 0; k < 17; k++)
         send_word(itlc_tb_pkg::REQ_DETECT, 10'(k * 60), 10'd900, 10'd10, 10'd10, 8'd255,
                   16'd0);
      send_tick();
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: idle_pct = 0;
            1: idle_pct = 71;
            2: idle_pct = 27;
            default: idle_pct = 0;
         endcase
         case (phase)
            0: begin
               write_reg(itlc_tb_pkg::REG_IOU_THRESHOLD, 40'd102);
               write_reg(itlc_tb_pkg::REG_CONF_DECAY, 40'd13);
               write_reg(itlc_tb_pkg::REG_KEEP_THRESHOLD, 40'd51);
            end
            1: begin
               write_reg(itlc_tb_pkg::REG_IOU_THRESHOLD, 40'd0);
               write_reg(itlc_tb_pkg::REG_CONF_DECAY, 40'd0);
               write_reg(itlc_tb_pkg::REG_KEEP_THRESHOLD, 40'd0);
            end
            2: begin
               write_reg(itlc_tb_pkg::REG_IOU_THRESHOLD, 40'd255);
               write_reg(itlc_tb_pkg::REG_CONF_DECAY, 40'd255);
               write_reg(itlc_tb_pkg::REG_KEEP_THRESHOLD, 40'd255);
            end
            default: begin
               write_reg(itlc_tb_pkg::REG_LINE_INSIDE, 40'({$urandom, $urandom}));
               write_reg(itlc_tb_pkg::REG_LINE_OUTSIDE, 40'({$urandom, $urandom}));
               write_reg(itlc_tb_pkg::REG_LINE_BOUND_ONE, pack_line(0, 0, 1023, 0));
               write_reg(itlc_tb_pkg::REG_IOU_THRESHOLD, 40'($urandom_range(30, 160)));
               write_reg(itlc_tb_pkg::REG_CONF_DECAY, 40'($urandom_range(1, 30)));
               write_reg(itlc_tb_pkg::REG_KEEP_THRESHOLD, 40'($urandom_range(20, 90)));
            end
         endcase
         random_phase(75);
         wait_drained();
         if (phase == 2) write_crossing_lines();
      end

      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("** iou_track_line_counter: PASSED **");
      end else begin
         $display("** iou_track_line_counter: FAILED **");
      end
      $finish;
   end

endmodule

// ===== iou_track_line_counter.f =====
sv/itlc_pkg.sv
sv/itlc_cell.sv
sv/itlc_side.sv
sv/iou_track_line_counter.sv
verif/itlc_tb_pkg.sv
verif/itlc_checker.sv
verif/tb_iou_track_line_counter.sv
